// ===== sv/sks_pkg.sv =====
// shared types, request codes and helpers for the sorted table key search
`default_nettype none

package sks_pkg;

   localparam int unsigned SKS_TABLE_DEPTH = 1024;
   localparam int unsigned IDX_W           = 10;
   localparam int unsigned KEY_W           = 32;
   localparam int unsigned KIND_W          = 3;

   // request codes
   localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EXACT      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIRST      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LAST       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIRST_NEAR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LAST_NEAR  = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]       req_type;
      logic [IDX_W-1:0]        entry_index;
      logic signed [KEY_W-1:0] key;
      logic [IDX_W-1:0]        low_index;
      logic [IDX_W-1:0]        high_index;
   } req_word_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] result_index;
   } rsp_word_type;

   // table access from the sequencer
   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [IDX_W-1:0] addr;
      logic [KEY_W-1:0] wdata;
   } mem_req_type;

   // finished search handed to the output stage
   typedef struct packed {
      logic             valid;
      logic             found;
      logic [IDX_W-1:0] index;
   } result_type;

   // absolute distance between two keys, without overflow
   function automatic logic [KEY_W:0] abs_gap(logic signed [KEY_W-1:0] a,
                                              logic signed [KEY_W-1:0] b);
      logic signed [KEY_W:0] d;
      d = (KEY_W+1)'(a) - (KEY_W+1)'(b);
      return (d < 0) ? (KEY_W+1)'(-d) : (KEY_W+1)'(d);
   endfunction

endpackage

`default_nettype wire

// ===== sv/sorted_table_key_search.sv =====
// top level: sorted key table with binary search and nearest search
//
// request words arrive on req_valid / req_stall / req_word; a write word
// stores one key into the table and gives no response, codes 6 and 7 are
// dropped, every search word gives exactly one response word on
// rsp_valid / rsp_stall / rsp_word (found plus index, index 0 on a miss)
// a write is stored as it is accepted; the next word is taken the cycle after
// each binary search probe drives the table read address, then compares
// on the registered read data
// first / last nearest: a lower bound pass, a pick of the nearest key,
// then an occurrence pass
// the single table read port paces the searches; one search is in flight
// at a time and req_stall stays high until its result is handed off
// the response sits in an output register, so the next word is accepted
// while a finished response still waits on rsp_stall; a search that ends
// while that register is full holds until it drains
// reset clears the sequencer and the response valid; table contents are
// undefined until written and need no clearing
`default_nettype none

module sorted_table_key_search import sks_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = SKS_TABLE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

   mem_req_type      mem;
   logic [KEY_W-1:0] rd_data;
   result_type       res;
   logic             out_free;
   logic             rsp_valid_ff;
   rsp_word_type     rsp_word_ff;

   // key table
   sks_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (AddrW'(mem.addr)),
      .wr_data (mem.wdata),
      .rd_en   (mem.rd_en),
      .rd_addr (AddrW'(mem.addr)),
      .rd_data (rd_data)
   );

   // search sequencer
   sks_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .mem       (mem),
      .rd_data   (rd_data),
      .res       (res),
      .res_take  (out_free)
   );

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid && out_free) begin
         rsp_word_ff.found        <= res.found;
         rsp_word_ff.result_index <= res.index;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== sv/sks_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module sks_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/sks_seq.sv =====
// search sequencer: binary search probes, final checks and nearest pick
`default_nettype none

module sks_seq import sks_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = SKS_TABLE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire req_word_type req_word,
   output logic              req_stall,
   output mem_req_type       mem,
   input  wire logic [KEY_W-1:0] rd_data,
   output result_type        res,
   input  wire logic         res_take
);

   localparam int unsigned LastInt = (TABLE_DEPTH - 1 < 1023) ? TABLE_DEPTH - 1 : 1023;
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(LastInt);

   typedef enum logic [3:0] {
      S_IDLE, S_PROBE, S_EVAL, S_CHK_A, S_CHK_B, S_CHK_C,
      S_NEAR_A, S_NEAR_B, S_NEAR_C, S_NEAR_D, S_DONE
   } state_type;

   state_type               state_ff;
   logic [KIND_W-1:0]       kind_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [IDX_W-1:0]        m_ff, n_ff, mid_ff;
   logic [IDX_W:0]          lo_ff, hi_ff;
   logic signed [KEY_W-1:0] prev_ff, cur_ff;
   logic [KEY_W:0]          gap_a_ff, gap_b_ff;
   logic                    res_found_ff;
   logic [IDX_W-1:0]        res_index_ff;

   logic [IDX_W:0]          mid_w;
   logic                    loop_go;
   logic                    is_first;
   logic                    near_simple;
   logic [IDX_W-1:0]        near_addr;
   logic signed [KEY_W-1:0] rd_key;
   logic [IDX_W-1:0]        n_sat;
   logic                    is_near_kind;

   assign rd_key       = signed'(rd_data);
   assign mid_w        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign is_first     = (kind_ff == KIND_FIRST);
   assign is_near_kind = (kind_ff == KIND_FIRST_NEAR) || (kind_ff == KIND_LAST_NEAR);
   assign near_simple  = (lo_ff > {1'b0, n_ff}) || (lo_ff == {1'b0, m_ff});
   assign n_sat        = (req_word.high_index > LastIdx) ? LastIdx : req_word.high_index;
   assign req_stall    = (state_ff != S_IDLE);

   always_comb begin
      if (kind_ff == KIND_EXACT) begin
         loop_go = 1'b1;
      end else if (is_near_kind) begin
         loop_go = (lo_ff < hi_ff);
      end else begin
         loop_go = ((hi_ff - lo_ff) > (IDX_W+1)'(1));
      end
   end

   always_comb begin
      if (lo_ff > {1'b0, n_ff}) begin
         near_addr = n_ff;
      end else if (lo_ff == {1'b0, m_ff}) begin
         near_addr = m_ff;
      end else begin
         near_addr = lo_ff[IDX_W-1:0] - IDX_W'(1);
      end
   end

   // table port
   always_comb begin
      mem = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_word.req_type == KIND_WRITE &&
                req_word.entry_index <= LastIdx) begin
               mem.wr_en = 1'b1;
               mem.addr  = req_word.entry_index;
               mem.wdata = req_word.key;
            end
         end
         S_PROBE: begin
            mem.rd_en = loop_go;
            mem.addr  = mid_w[IDX_W-1:0];
         end
         S_CHK_A: begin
            mem.rd_en = 1'b1;
            mem.addr  = is_first ? lo_ff[IDX_W-1:0] : hi_ff[IDX_W-1:0];
         end
         S_CHK_B: begin
            mem.rd_en = 1'b1;
            mem.addr  = is_first ? hi_ff[IDX_W-1:0] : lo_ff[IDX_W-1:0];
         end
         S_NEAR_A: begin
            mem.rd_en = 1'b1;
            mem.addr  = near_addr;
         end
         S_NEAR_B: begin
            mem.rd_en = !near_simple;
            mem.addr  = lo_ff[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   assign res.valid = (state_ff == S_DONE);
   assign res.found = res_found_ff;
   assign res.index = res_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         res_found_ff <= 1'b0;
         res_index_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_word.req_type != KIND_WRITE &&
                   req_word.req_type <= KIND_LAST_NEAR) begin
                  kind_ff <= req_word.req_type;
                  key_ff  <= req_word.key;
                  m_ff    <= req_word.low_index;
                  n_ff    <= n_sat;
                  lo_ff   <= {1'b0, req_word.low_index};
                  if (req_word.req_type == KIND_FIRST_NEAR ||
                      req_word.req_type == KIND_LAST_NEAR) begin
                     hi_ff <= {1'b0, n_sat} + (IDX_W+1)'(1);
                  end else begin
                     hi_ff <= {1'b0, n_sat};
                  end
                  if (req_word.low_index > n_sat) begin
                     // empty range
                     res_found_ff <= 1'b0;
                     res_index_ff <= '0;
                     state_ff     <= S_DONE;
                  end else begin
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               mid_ff <= mid_w[IDX_W-1:0];
               if (loop_go) begin
                  state_ff <= S_EVAL;
               end else if (is_near_kind) begin
                  state_ff <= S_NEAR_A;
               end else begin
                  state_ff <= S_CHK_A;
               end
            end
            S_EVAL: begin
               state_ff <= S_PROBE;
               priority if (kind_ff == KIND_EXACT) begin
                  if (rd_key == key_ff) begin
                     res_found_ff <= 1'b1;
                     res_index_ff <= mid_ff;
                     state_ff     <= S_DONE;
                  end else if (rd_key < key_ff) begin
                     if ({1'b0, mid_ff} == hi_ff) begin
                        res_found_ff <= 1'b0;
                        res_index_ff <= '0;
                        state_ff     <= S_DONE;
                     end else begin
                        lo_ff <= {1'b0, mid_ff} + (IDX_W+1)'(1);
                     end
                  end else begin
                     if ({1'b0, mid_ff} == lo_ff) begin
                        res_found_ff <= 1'b0;
                        res_index_ff <= '0;
                        state_ff     <= S_DONE;
                     end else begin
                        hi_ff <= {1'b0, mid_ff} - (IDX_W+1)'(1);
                     end
                  end
               end else if (kind_ff == KIND_FIRST) begin
                  if (rd_key < key_ff) begin
                     lo_ff <= {1'b0, mid_ff};
                  end else begin
                     hi_ff <= {1'b0, mid_ff};
                  end
               end else if (kind_ff == KIND_LAST) begin
                  if (rd_key > key_ff) begin
                     hi_ff <= {1'b0, mid_ff};
                  end else begin
                     lo_ff <= {1'b0, mid_ff};
                  end
               end else begin
                  // lower bound search for the nearest pass
                  if (rd_key < key_ff) begin
                     lo_ff <= {1'b0, mid_ff} + (IDX_W+1)'(1);
                  end else begin
                     hi_ff <= {1'b0, mid_ff};
                  end
               end
            end
            S_CHK_A: begin
               state_ff <= S_CHK_B;
            end
            S_CHK_B: begin
               if (rd_key == key_ff) begin
                  res_found_ff <= 1'b1;
                  res_index_ff <= is_first ? lo_ff[IDX_W-1:0] : hi_ff[IDX_W-1:0];
                  state_ff     <= S_DONE;
               end else begin
                  state_ff <= S_CHK_C;
               end
            end
            S_CHK_C: begin
               res_found_ff <= (rd_key == key_ff);
               if (rd_key == key_ff) begin
                  res_index_ff <= is_first ? hi_ff[IDX_W-1:0] : lo_ff[IDX_W-1:0];
               end else begin
                  res_index_ff <= '0;
               end
               state_ff <= S_DONE;
            end
            S_NEAR_A: begin
               state_ff <= S_NEAR_B;
            end
            S_NEAR_B: begin
               if (near_simple) begin
                  // nearest key known, rerun as an occurrence search
                  key_ff   <= rd_key;
                  lo_ff    <= {1'b0, m_ff};
                  hi_ff    <= {1'b0, n_ff};
                  kind_ff  <= (kind_ff == KIND_FIRST_NEAR) ? KIND_FIRST : KIND_LAST;
                  state_ff <= S_PROBE;
               end else begin
                  prev_ff  <= rd_key;
                  gap_a_ff <= abs_gap(rd_key, key_ff);
                  state_ff <= S_NEAR_C;
               end
            end
            S_NEAR_C: begin
               cur_ff   <= rd_key;
               gap_b_ff <= abs_gap(rd_key, key_ff);
               state_ff <= S_NEAR_D;
            end
            S_NEAR_D: begin
               // a tie goes to the larger key
               key_ff   <= (gap_a_ff < gap_b_ff) ? prev_ff : cur_ff;
               lo_ff    <= {1'b0, m_ff};
               hi_ff    <= {1'b0, n_ff};
               kind_ff  <= (kind_ff == KIND_FIRST_NEAR) ? KIND_FIRST : KIND_LAST;
               state_ff <= S_PROBE;
            end
            S_DONE: begin
               if (res_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem.wr_en && mem.rd_en))
      else $error("table read and write in the same cycle");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      mem.rd_en |-> (mem.addr >= m_ff && mem.addr <= n_ff))
      else $error("table read outside the search range");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      res.valid && !res.found |-> res.index == '0)
      else $error("miss reported with a nonzero index");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      res.valid && !res_take |=> res.valid && $stable(res.index) && $stable(res.found))
      else $error("pending result dropped or changed");

endmodule

`default_nettype wire
